FILE: sv/ttcw_pkg.sv
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared types and constants of the text terminal character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcw_pkg;

    // screen geometry
    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TAB_WIDTH   = 3;
    localparam int SCREEN_SIZE = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(SCREEN_SIZE);
    localparam int CUR_W  = 11;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CNT_MAX = (COLUMNS > TAB_WIDTH) ? COLUMNS : TAB_WIDTH;
    localparam int CNT_W  = $clog2(CNT_MAX + 1);
    localparam int CELL_W = 16;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_LOCK  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // character codes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [7:0] STYLE_RESET = 8'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  character;
        logic [10:0] cell_address;
    } t_cmd;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic        scrolled;
        logic [7:0]  cell_character;
        logic [7:0]  cell_style;
    } t_result;

    typedef struct packed {
        logic [7:0] style;
        logic [7:0] chr;
    } t_cell;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_cell             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PUT,
        S_BACK,
        S_READ,
        S_SCR_COPY,
        S_SCR_BLANK
    } t_state;

endpackage

`default_nettype wire

FILE: sv/text_terminal_char_writer.sv
// ----------------------------------------------------------------------------
// text_terminal_char_writer
// Text-mode terminal keeping a screen of character/style cells and a cursor.
// ----------------------------------------------------------------------------
// After reset the block clears the 2000-cell screen memory one cell a cycle,
// so busy stays high through that pass. An item is taken when start is high
// and busy is low; its one result appears on o_result for a single cycle
// with o_result_valid high and must be taken then. A lock or unused item
// answers in the cycle after acceptance, a read, backspace or printable
// character after its state (S_READ, S_BACK, S_PUT) and the result register.
// Tabs write TAB_WIDTH cells, newlines up to COLUMNS, one cell write per
// cycle through the single write port of the screen memory unless a scroll
// intervenes: it copies one cell a cycle through that port, then blanks the
// last row. The style register may be written at any time while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_char_writer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ttcw_pkg::t_cmd    i_cmd,
    output logic                   o_result_valid,
    output ttcw_pkg::t_result      o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_wdata
);

    import ttcw_pkg::*;

    t_mem_req          w_mem;
    logic [CELL_W-1:0] w_rdata;
    t_cell             w_rcell;

    assign w_rcell = t_cell'(w_rdata);

    ttcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rdata     (w_rcell),
        .o_mem       (w_mem),
        .o_busy      (busy),
        .o_res_valid (o_result_valid),
        .o_res       (o_result)
    );

    ttcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (SCREEN_SIZE)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

endmodule

`default_nettype wire

FILE: sv/ttcw_ram.sv
// ----------------------------------------------------------------------------
// ttcw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/ttcw_ctrl.sv
// ----------------------------------------------------------------------------
// ttcw_ctrl
// Sequencer of the terminal: cursor, lock and style state, cell writes,
// scroll copy and reset clearing pass over the screen memory.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire ttcw_pkg::t_cmd   i_cmd,
    input  wire logic             i_cfg_we,
    input  wire logic [7:0]       i_cfg_wdata,
    input  wire ttcw_pkg::t_cell  i_rdata,
    output ttcw_pkg::t_mem_req    o_mem,
    output logic                  o_busy,
    output logic                  o_res_valid,
    output ttcw_pkg::t_result     o_res
);

    import ttcw_pkg::*;

    localparam logic [CUR_W-1:0]  CUR_END   = CUR_W'(SCREEN_SIZE);
    localparam logic [CUR_W-1:0]  CUR_COLS  = CUR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] IDX_LAST  = ADDR_W'(SCREEN_SIZE - 1);
    localparam logic [ADDR_W-1:0] IDX_COPY  = ADDR_W'(SCREEN_SIZE - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] IDX_COLS  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

    t_state            r_state, n_state;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CUR_W-1:0]  r_lock, n_lock;
    logic [7:0]        r_style;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [7:0]        r_char, n_char;
    logic              r_scrolled, n_scrolled;
    logic              r_read_ok, n_read_ok;
    logic              r_res_valid, n_res_valid;
    t_result           r_res, n_res;
    logic              w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_idx == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd.kind)
                        KIND_WRITE: begin
                            if (i_cmd.character == CH_BACKSPACE) begin
                                n_state = S_BACK;
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        KIND_READ: n_state = S_READ;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_PUT: begin
                if (r_cursor == CUR_END) begin
                    n_state = S_SCR_COPY;
                end else if (r_count == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_SCR_COPY: begin
                if (r_idx == IDX_COPY) begin
                    n_state = S_SCR_BLANK;
                end
            end
            S_SCR_BLANK: begin
                if (r_idx == IDX_LAST) begin
                    n_state = S_PUT;
                end
            end
            S_BACK:  n_state = S_IDLE;
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_cursor    = r_cursor;
        n_col       = r_col;
        n_lock      = r_lock;
        n_idx       = r_idx;
        n_count     = r_count;
        n_char      = r_char;
        n_scrolled  = r_scrolled;
        n_read_ok   = r_read_ok;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_mem       = '0;
        case (r_state)
            S_CLEAR: begin
                o_mem.we          = 1'b1;
                o_mem.waddr       = r_idx;
                o_mem.wdata.style = STYLE_RESET;
                o_mem.wdata.chr   = CH_SPACE;
                n_idx             = r_idx + ADDR_W'(1);
            end
            S_IDLE: begin
                if (i_start) begin
                    n_scrolled = 1'b0;
                    case (i_cmd.kind)
                        KIND_WRITE: begin
                            if (i_cmd.character == CH_NEWLINE) begin
                                n_char = CH_SPACE;
                                if (r_col == '0) begin
                                    n_count = CNT_W'(COLUMNS);
                                end else begin
                                    n_count = CNT_W'(COLUMNS) - CNT_W'(r_col);
                                end
                            end else if (i_cmd.character == CH_TAB) begin
                                n_char  = CH_SPACE;
                                n_count = CNT_W'(TAB_WIDTH);
                            end else begin
                                n_char  = i_cmd.character;
                                n_count = CNT_W'(1);
                            end
                        end
                        KIND_READ: begin
                            o_mem.re  = 1'b1;
                            o_mem.raddr = ADDR_W'(i_cmd.cell_address);
                            n_read_ok = (i_cmd.cell_address < CUR_END);
                        end
                        KIND_LOCK: begin
                            n_lock      = r_cursor;
                            n_res_valid = 1'b1;
                            n_res       = '{r_cursor, 1'b0, 8'd0, 8'd0};
                        end
                        default: begin
                            n_res_valid = 1'b1;
                            n_res       = '{r_cursor, 1'b0, 8'd0, 8'd0};
                        end
                    endcase
                end
            end
            S_PUT: begin
                if (r_cursor == CUR_END) begin
                    // scroll: start reading the second row
                    n_idx       = '0;
                    o_mem.re    = 1'b1;
                    o_mem.raddr = IDX_COLS;
                end else begin
                    o_mem.we          = 1'b1;
                    o_mem.waddr       = ADDR_W'(r_cursor);
                    o_mem.wdata.style = r_style;
                    o_mem.wdata.chr   = r_char;
                    n_cursor          = r_cursor + CUR_W'(1);
                    n_col             = (r_col == COL_LAST) ? '0 : r_col + COL_W'(1);
                    n_count           = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_res_valid = 1'b1;
                        n_res       = '{n_cursor, r_scrolled, 8'd0, 8'd0};
                    end
                end
            end
            S_SCR_COPY: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                o_mem.wdata = i_rdata;
                n_idx       = r_idx + ADDR_W'(1);
                if (r_idx != IDX_COPY) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_idx + IDX_COLS + ADDR_W'(1);
                end
            end
            S_SCR_BLANK: begin
                o_mem.we          = 1'b1;
                o_mem.waddr       = r_idx;
                o_mem.wdata.style = r_style;
                o_mem.wdata.chr   = CH_SPACE;
                n_idx             = r_idx + ADDR_W'(1);
                if (r_idx == IDX_LAST) begin
                    n_cursor   = r_cursor - CUR_COLS;
                    n_scrolled = 1'b1;
                end
            end
            S_BACK: begin
                if ((r_cursor != '0) && (r_cursor > r_lock)) begin
                    n_cursor          = r_cursor - CUR_W'(1);
                    n_col             = (r_col == '0) ? COL_LAST : r_col - COL_W'(1);
                    o_mem.we          = 1'b1;
                    o_mem.waddr       = ADDR_W'(n_cursor);
                    o_mem.wdata.style = r_style;
                    o_mem.wdata.chr   = CH_SPACE;
                end
                n_res_valid = 1'b1;
                n_res       = '{n_cursor, 1'b0, 8'd0, 8'd0};
            end
            S_READ: begin
                n_res_valid = 1'b1;
                n_res.cursor_position = r_cursor;
                n_res.scrolled        = 1'b0;
                n_res.cell_character  = r_read_ok ? i_rdata.chr : 8'd0;
                n_res.cell_style      = r_read_ok ? i_rdata.style : 8'd0;
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cursor    <= '0;
            r_col       <= '0;
            r_lock      <= '0;
            r_style     <= STYLE_RESET;
            r_idx       <= '0;
            r_scrolled  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_lock      <= n_lock;
            r_idx       <= n_idx;
            r_scrolled  <= n_scrolled;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_style <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count   <= n_count;
        r_char    <= n_char;
        r_read_ok <= n_read_ok;
        r_res     <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // checks
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor <= CUR_END) && (r_col <= COL_LAST))
        else $error("cursor out of range");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !r_res_valid)
        else $error("result during clearing pass");

    a_scroll_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCR_BLANK) && (r_idx == IDX_LAST)
        |=> (r_state == S_PUT) && r_scrolled && (r_cursor == CUR_END - CUR_COLS))
        else $error("scroll did not return to cell write");

    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_cmd.kind == KIND_READ) |=> (r_state == S_READ) ##1 r_res_valid)
        else $error("read item did not produce a result");

endmodule

`default_nettype wire
